@@ src/mig_pkg.sv @@
// Package for the Gauss-Jordan matrix inverse block.
// Holds dimensions, fixed-point constants and shared types; no dependencies.
`default_nettype none
package mig_pkg;
   localparam int MaxDim   = 4;
   localparam int FracBits = 16;
   localparam int Cols     = 2 * MaxDim;
   localparam int RowW     = $clog2(MaxDim);
   localparam int ColW     = $clog2(Cols);
   localparam int AddrW    = RowW + ColW;
   localparam int CntW     = $clog2(MaxDim * MaxDim + 1);
   localparam int DimW     = $clog2(MaxDim + 1);
   localparam logic signed [31:0] FxOne = 32'sd1 <<< FracBits;

   // Operation codes for the shared arithmetic unit.
   typedef enum logic [1:0] {
      OP_DIV = 2'b01,
      OP_MSB = 2'b10
   } op_type;

   // Request from the sequencer to the arithmetic unit.
   typedef struct packed {
      logic              start;
      op_type            op;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] c;
   } alu_req_type;

   // Saturate a 64-bit value to 32 bits signed.
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) r = 32'sh7fffffff;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction
endpackage
`default_nettype wire

@@ src/mig_alu.sv @@
// Shared arithmetic unit: multiply-subtract with a registered product, or a restoring
// divider that produces one quotient bit per cycle. Uses mig_pkg.
`default_nettype none
module mig_alu
   import mig_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire alu_req_type       req,
   output logic                   done,
   output logic signed [31:0]     result
);
   localparam int DivW = 32 + FracBits + 1;
   localparam int StepW = $clog2(DivW + 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_MUL  = 3'b010,
      S_DIV  = 3'b100
   } alu_state_type;

   alu_state_type state_ff, state_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [31:0] a_ff, a_in;
   logic [DivW-1:0] num_ff, num_in;
   logic [DivW-1:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic neg_ff, neg_in;
   logic [StepW-1:0] step_ff, step_in;
   logic done_ff, done_in;
   logic signed [31:0] res_ff, res_in;

   logic signed [63:0] quot_q;
   logic signed [63:0] trunc_p;
   logic signed [63:0] diff;
   logic [DivW:0] trial;
   logic [DivW-1:0] rem_sh;
   logic signed [63:0] num_s;
   logic [63:0] num_abs;

   always_comb begin
      state_in = state_ff;
      prod_in  = prod_ff;
      a_in     = a_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      res_in   = res_ff;
      trunc_p  = '0;
      diff     = '0;
      trial    = '0;
      rem_sh   = '0;
      quot_q   = '0;
      num_s    = 64'(req.a) <<< FracBits;
      num_abs  = num_s[63] ? 64'(-num_s) : 64'(num_s);
      unique case (state_ff)
         S_IDLE: begin
            if (req.start) begin
               if (req.op == OP_MSB) begin
                  // Register the product before the subtract.
                  prod_in  = 64'(req.b) * 64'(req.c);
                  a_in     = req.a;
                  state_in = S_MUL;
               end else begin
                  num_in  = num_abs[DivW-1:0];
                  den_in  = req.b[31] ? 32'(-req.b) : 32'(req.b);
                  neg_in  = num_s[63] ^ req.b[31];
                  rem_in  = '0;
                  step_in = StepW'(DivW);
                  state_in = S_DIV;
               end
            end
         end
         S_MUL: begin
            // Truncate toward zero when dropping the fraction bits.
            if (prod_ff[63])
               trunc_p = -((-prod_ff) >>> FracBits);
            else
               trunc_p = prod_ff >>> FracBits;
            diff     = 64'(a_ff) - trunc_p;
            res_in   = sat32(diff);
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         S_DIV: begin
            // One restoring quotient bit per cycle.
            rem_sh = {rem_ff[DivW-2:0], num_ff[DivW-1]};
            trial  = {1'b0, rem_sh} - {{(DivW-31){1'b0}}, den_ff};
            num_in = num_ff << 1;
            if (!trial[DivW]) begin
               rem_in = trial[DivW-1:0];
               num_in[0] = 1'b1;
            end else begin
               rem_in = rem_sh;
            end
            step_in = step_ff - 1'b1;
            if (step_ff == StepW'(1)) begin
               quot_q   = 64'(num_in);
               res_in   = sat32(neg_ff ? -quot_q : quot_q);
               done_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      prod_ff <= prod_in;
      a_ff    <= a_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      step_ff <= step_in;
      res_ff  <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;
endmodule
`default_nettype wire

@@ src/matrix_inverse_gauss_jordan.sv @@
// Top level of the Gauss-Jordan matrix inverse: sequencer, matrix store and
// output stage. Uses mig_pkg and mig_alu.
//
// Usage: write the dimension N (1..4) on the csr_ channel while idle; a
// write restarts any partial load. Send N*N signed Q16.16 elements on the
// req_ channel in row-major order, one item per cycle while req_tready is
// high. After the last element the block drops req_tready and inverts the
// matrix joined with an identity without pivoting, using one shared unit:
// each normalized element is read, issued, put through a 49-step serial
// divide and written back to the store, each multiply-subtract is issued
// once the pivot-row element lands, and each cleared row first fetches its
// coefficient. The N*N inverse elements then leave on rsp_ row by row, one
// at a time, the next read issued only once the output register is free,
// rsp_tlast on the final one and the singular flag in rsp_tuser on every
// item. A stall on rsp_tready holds the current item; the next matrix is
// accepted only after the last result is taken. Reset clears the control
// state and sets N to 4; the store holds no defined data until loaded.
`default_nettype none
module matrix_inverse_gauss_jordan
   import mig_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_data,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // element_in
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // element_out
   output logic             rsp_tlast,   // last_of_matrix
   output logic             rsp_tuser    // singular
);
   typedef enum logic [10:0] {
      M_LOAD  = 11'b00000000001,
      M_IDENT = 11'b00000000010,
      M_PREAD = 11'b00000000100,
      M_PWAIT = 11'b00000001000,
      M_NRD   = 11'b00000010000,
      M_NOP   = 11'b00000100000,
      M_NWAIT = 11'b00001000000,
      M_CRD   = 11'b00010000000,
      M_CRD2  = 11'b00100000000,
      M_CWAIT = 11'b01000000000,
      M_OUT   = 11'b10000000000
   } seq_state_type;

   seq_state_type state_ff, state_in;
   logic [2:0] size_ff, size_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [RowW-1:0] lr_ff, lr_in;
   logic [RowW-1:0] lc_ff, lc_in;
   logic sing_ff, sing_in;
   logic bwd_ff, bwd_in;           // back-substitution phase
   logic [RowW-1:0] piv_ff, piv_in; // pivot row i
   logic [RowW-1:0] row_ff, row_in; // target row k
   logic [ColW-1:0] col_ff, col_in;
   logic signed [31:0] pv_ff, pv_in;   // pivot or coefficient
   logic signed [31:0] ra_ff, ra_in;   // element of target row
   logic coef_ok_ff, coef_ok_in;       // coefficient of the target row fetched
   logic out_v_ff, out_v_in;
   logic out_l_ff, out_l_in;
   logic [31:0] out_d_ff, out_d_in;
   logic issue_ff;
   logic oread_ff, oread_in;

   logic signed [31:0] mem [MaxDim*Cols];
   logic we;
   logic [AddrW-1:0] waddr, raddr;
   logic signed [31:0] wdata, rdata_ff;
   alu_req_type alu_req;
   logic alu_done;
   logic signed [31:0] alu_res;

   logic [RowW:0] n_eff;
   logic [RowW-1:0] nm1;
   logic [ColW:0] cols;
   logic [CntW-1:0] total;

   function automatic logic [AddrW-1:0] addr(input logic [RowW-1:0] r,
                                             input logic [ColW-1:0] c);
      return {r, c};
   endfunction

   // Clamp the configured size.
   always_comb begin
      if (size_ff == 3'd0) n_eff = (RowW+1)'(1);
      else if (32'(size_ff) > MaxDim) n_eff = (RowW+1)'(MaxDim);
      else n_eff = (RowW+1)'(size_ff);
      nm1   = RowW'(n_eff - 1'b1);
      cols  = (ColW+1)'(n_eff) << 1;
      total = CntW'(n_eff) * CntW'(n_eff);
   end

   // Matrix store, one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   mig_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .req    (alu_req),
      .done   (alu_done),
      .result (alu_res)
   );

   assign csr_ready  = (state_ff == M_LOAD);
   assign req_tready = (state_ff == M_LOAD) && !csr_valid;

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      size_in    = size_ff;
      cnt_in     = cnt_ff;
      lr_in      = lr_ff;
      lc_in      = lc_ff;
      sing_in    = sing_ff;
      bwd_in     = bwd_ff;
      piv_in     = piv_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      pv_in      = pv_ff;
      ra_in      = ra_ff;
      coef_ok_in = coef_ok_ff;
      out_v_in   = out_v_ff;
      out_l_in   = out_l_ff;
      out_d_in   = out_d_ff;
      we         = 1'b0;
      waddr      = '0;
      wdata      = '0;
      raddr      = '0;
      alu_req    = '{start: 1'b0, op: OP_MSB, a: '0, b: '0, c: '0};
      unique case (state_ff)
         M_LOAD: begin
            if (csr_valid) begin
               size_in = csr_data;
               cnt_in  = '0;
               lr_in   = '0;
               lc_in   = '0;
            end else if (req_tvalid) begin
               we    = 1'b1;
               waddr = addr(lr_ff, ColW'(lc_ff));
               wdata = req_tdata;
               cnt_in = cnt_ff + 1'b1;
               if (lc_ff == nm1) begin
                  lc_in = '0;
                  lr_in = lr_ff + 1'b1;
               end else begin
                  lc_in = lc_ff + 1'b1;
               end
               if (cnt_ff + 1'b1 == total) begin
                  state_in = M_IDENT;
                  lr_in    = '0;
                  lc_in    = '0;
                  sing_in  = 1'b0;
               end
            end
         end
         M_IDENT: begin
            // Write the identity half, one entry per cycle.
            we    = 1'b1;
            waddr = addr(lr_ff, ColW'(n_eff) + ColW'(lc_ff));
            wdata = (lr_ff == lc_ff) ? FxOne : 32'sd0;
            if (lc_ff == nm1) begin
               lc_in = '0;
               lr_in = lr_ff + 1'b1;
               if (lr_ff == nm1) begin
                  piv_in   = '0;
                  bwd_in   = 1'b0;
                  state_in = M_PREAD;
               end
            end else begin
               lc_in = lc_ff + 1'b1;
            end
         end
         M_PREAD: begin
            raddr      = addr(piv_ff, ColW'(piv_ff));
            col_in     = (piv_ff == nm1) ? ColW'(nm1) : '0;
            coef_ok_in = 1'b0;
            state_in   = M_PWAIT;
         end
         M_PWAIT: begin
            pv_in = rdata_ff;
            if (rdata_ff == 32'sd0) begin
               sing_in = 1'b1;
               if (piv_ff == nm1) begin
                  bwd_in = 1'b1;
                  if (piv_ff == '0) state_in = M_OUT;
                  else begin
                     row_in = piv_ff - 1'b1;
                     col_in = '0;
                     state_in = M_CRD;
                  end
               end else begin
                  row_in = piv_ff + 1'b1;
                  col_in = '0;
                  state_in = M_CRD;
               end
            end else begin
               state_in = M_NRD;
            end
            if (state_in == M_OUT) begin
               lr_in = '0;
               lc_in = '0;
               cnt_in = '0;
            end
         end
         M_NRD: begin
            raddr    = addr(piv_ff, col_ff);
            state_in = M_NOP;
         end
         M_NOP: begin
            alu_req = '{start: 1'b1, op: OP_DIV, a: rdata_ff, b: pv_ff, c: '0};
            state_in = M_NWAIT;
         end
         M_NWAIT: begin
            if (alu_done) begin
               we    = 1'b1;
               waddr = addr(piv_ff, col_ff);
               wdata = alu_res;
               if ((ColW+1)'(col_ff) + 1'b1 == cols) begin
                  if (piv_ff == nm1) begin
                     bwd_in = 1'b1;
                     if (piv_ff == '0) begin
                        state_in = M_OUT;
                        lr_in = '0;
                        lc_in = '0;
                        cnt_in = '0;
                     end else begin
                        row_in = piv_ff - 1'b1;
                        col_in = '0;
                        state_in = M_CRD;
                     end
                  end else begin
                     row_in = piv_ff + 1'b1;
                     col_in = '0;
                     state_in = M_CRD;
                  end
               end else begin
                  col_in   = col_ff + 1'b1;
                  state_in = M_NRD;
               end
            end
         end
         M_CRD: begin
            // Fetch the coefficient once per row, then per column the row's element.
            if (!coef_ok_ff) raddr = addr(row_ff, ColW'(piv_ff));
            else raddr = addr(row_ff, col_ff);
            state_in = M_CRD2;
         end
         M_CRD2: begin
            if (!coef_ok_ff) begin
               pv_in      = rdata_ff;
               coef_ok_in = 1'b1;
               state_in   = M_CRD;
            end else begin
               ra_in    = rdata_ff;
               raddr    = addr(piv_ff, col_ff);
               state_in = M_CWAIT;
            end
         end
         M_CWAIT: begin
            // Issue on the first cycle here, when the pivot-row element lands.
            if (issue_ff) begin
               alu_req = '{start: 1'b1, op: OP_MSB, a: ra_ff, b: rdata_ff, c: pv_ff};
            end
            if (alu_done) begin
               we    = 1'b1;
               waddr = addr(row_ff, col_ff);
               wdata = alu_res;
               if ((ColW+1)'(col_ff) + 1'b1 == cols) begin
                  col_in     = '0;
                  coef_ok_in = 1'b0;
                  if (!bwd_ff) begin
                     if (row_ff == nm1) begin
                        piv_in   = piv_ff + 1'b1;
                        state_in = M_PREAD;
                     end else begin
                        row_in   = row_ff + 1'b1;
                        state_in = M_CRD;
                     end
                  end else begin
                     if (row_ff == '0) begin
                        if (piv_ff == RowW'(1)) begin
                           state_in = M_OUT;
                           lr_in = '0;
                           lc_in = '0;
                           cnt_in = '0;
                        end else begin
                           piv_in   = piv_ff - 1'b1;
                           row_in   = piv_ff - RowW'(2);
                           state_in = M_CRD;
                        end
                     end else begin
                        row_in   = row_ff - 1'b1;
                        state_in = M_CRD;
                     end
                  end
               end else begin
                  col_in   = col_ff + 1'b1;
                  state_in = M_CRD;
               end
            end
         end
         M_OUT: begin
            // Stream the right half with a one-entry output register.
            if (!out_v_ff || rsp_tready) begin
               out_v_in = 1'b0;
               if (cnt_ff != total || !out_v_ff) begin
                  if (cnt_ff == total) begin
                     state_in = M_LOAD;
                     cnt_in   = '0;
                     lr_in    = '0;
                     lc_in    = '0;
                  end
               end
            end
            if (cnt_ff != total) begin
               raddr = addr(lr_ff, ColW'(n_eff) + ColW'(lc_ff));
            end
            // Fill the output register from the registered read.
            if (oread_ff) begin
               out_v_in = 1'b1;
               out_d_in = rdata_ff;
               out_l_in = (cnt_ff + 1'b1 == total);
               cnt_in   = cnt_ff + 1'b1;
               if (lc_ff == nm1) begin
                  lc_in = '0;
                  lr_in = lr_ff + 1'b1;
               end else begin
                  lc_in = lc_ff + 1'b1;
               end
            end
         end
         default: state_in = M_LOAD;
      endcase
   end

   // Read request for the next result, issued once the output register is free.
   always_comb begin
      oread_in = 1'b0;
      if (state_ff == M_OUT && cnt_ff != total && !oread_ff && !out_v_ff)
         oread_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_LOAD;
         size_ff  <= 3'd4;
         cnt_ff   <= '0;
         lr_ff    <= '0;
         lc_ff    <= '0;
         sing_ff  <= 1'b0;
         bwd_ff   <= 1'b0;
         out_v_ff <= 1'b0;
         issue_ff <= 1'b0;
         oread_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         size_ff  <= size_in;
         cnt_ff   <= cnt_in;
         lr_ff    <= lr_in;
         lc_ff    <= lc_in;
         sing_ff  <= sing_in;
         bwd_ff   <= bwd_in;
         issue_ff <= (state_ff == M_CRD2) && coef_ok_ff;
         oread_ff <= oread_in;
         out_v_ff <= out_v_in;
      end
      piv_ff     <= piv_in;
      row_ff     <= row_in;
      col_ff     <= col_in;
      pv_ff      <= pv_in;
      ra_ff      <= ra_in;
      coef_ok_ff <= coef_ok_in;
      out_l_ff   <= out_l_in;
      out_d_ff   <= out_d_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;
   assign rsp_tlast  = out_l_ff;
   assign rsp_tuser  = sing_ff;
endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Testbench for the Gauss-Jordan matrix inverse block: random and directed matrices,
// predicted in fixed point and checked item by item. Depends on mig_pkg and the RTL.
`default_nettype none
module tb
   import mig_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // Predictor of the inverse with its own store, plus the queue of expected items.
   class inverse_scoreboard;
      logic signed [31:0] grid [MaxDim][Cols];
      int unsigned        loaded;
      int unsigned        dim_reg;
      logic [31:0]        exp_elem [$];
      bit                 exp_last [$];
      bit                 exp_sing [$];
      int                 errors;
      int                 matrices;
      int                 singular_count;

      function new();
         loaded = 0;
         dim_reg = 4;
         errors = 0;
         matrices = 0;
         singular_count = 0;
         foreach (grid[i, j]) grid[i][j] = 0;
      endfunction

      function int unsigned dim_eff();
         int unsigned n;
         n = dim_reg & 7;
         if (n < 1) n = 1;
         if (n > MaxDim) n = MaxDim;
         return n;
      endfunction

      function void set_dim(int unsigned v);
         dim_reg = v & 7;
         loaded = 0;
      endfunction

      function logic signed [31:0] clamp(longint v);
         if (v > 64'sd2147483647) return 32'sh7fffffff;
         if (v < -64'sd2147483648) return 32'sh80000000;
         return v[31:0];
      endfunction

      // Divide a row by its pivot; a zero pivot leaves the row and marks singular.
      function void scale_row(int r, int from, int cols, ref bit sing);
         longint p;
         p = grid[r][r];
         if (p == 0) begin
            sing = 1;
            return;
         end
         for (int j = from; j < cols; j++)
            grid[r][j] = clamp((longint'(grid[r][j]) * (longint'(1) << FracBits)) / p);
      endfunction

      // Subtract a multiple of the pivot row, using the coefficient read first.
      function void eliminate_row(int k, int i, int cols);
         longint coeff;
         coeff = grid[k][i];
         for (int j = 0; j < cols; j++)
            grid[k][j] = clamp(longint'(grid[k][j]) -
                               (longint'(grid[i][j]) * coeff) / (longint'(1) << FracBits));
      endfunction

      function void note_element(logic [31:0] d);
         int unsigned n;
         int          cols;
         bit          sing;
         n = dim_eff();
         if (loaded >= n * n) loaded = 0;
         grid[loaded / n][loaded % n] = d;
         loaded++;
         if (loaded < n * n) return;
         cols = 2 * n;
         sing = 0;
         for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
               grid[i][n + j] = (i == j) ? FxOne : 32'sd0;
         for (int i = 0; i + 1 < n; i++) begin
            scale_row(i, 0, cols, sing);
            for (int k = i + 1; k < n; k++) eliminate_row(k, i, cols);
         end
         scale_row(n - 1, n - 1, cols, sing);
         for (int i = n - 1; i > 0; i--)
            for (int k = i; k > 0; k--) eliminate_row(k - 1, i, cols);
         for (int k = 0; k < n * n; k++) begin
            exp_elem.push_back(grid[k / n][n + k % n]);
            exp_last.push_back(k + 1 == n * n);
            exp_sing.push_back(sing);
         end
         matrices++;
         if (sing) singular_count++;
         loaded = 0;
      endfunction

      function void check_result(logic [31:0] d, logic l, logic s);
         logic [31:0] e;
         bit          el;
         bit          es;
         if (exp_elem.size() == 0) begin
            $display("%0t: unexpected item data=%h last=%b singular=%b", $time, d, l, s);
            errors++;
            return;
         end
         e = exp_elem.pop_front();
         el = exp_last.pop_front();
         es = exp_sing.pop_front();
         if (d !== e) begin
            $display("%0t: element expected %h actual %h", $time, e, d);
            errors++;
         end
         if (l !== el) begin
            $display("%0t: last expected %b actual %b", $time, el, l);
            errors++;
         end
         if (s !== es) begin
            $display("%0t: singular expected %b actual %b", $time, es, s);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // element_in
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // element_out
   logic        rsp_tlast;   // last_of_matrix
   logic        rsp_tuser;   // singular

   inverse_scoreboard board;
   bit                hold_off;
   bit                sink_mode;   // 1: no random stalls on the result side
   int                results_seen;

   matrix_inverse_gauss_jordan i_dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Send one element and wait for it to be taken; valid stays up afterwards
   // until a gap, a size write or a pause drops it.
   task automatic send_element(logic [31:0] d, bit gaps);
      int g;
      g = gaps ? gap_len() : 0;
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_element(d);
      @(negedge clock);
   endtask

   task automatic write_size(logic [2:0] v);
      req_tvalid <= 1'b0;
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.set_dim(v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stop offering items and wait until all expected items are out.
   task automatic wait_empty();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (board.exp_elem.size() != 0) @(negedge clock);
   endtask

   // Wait until all expected items are out, then let the block settle.
   task automatic drain();
      wait_empty();
      repeat (20) @(negedge clock);
   endtask

   // Random element: mostly moderate Q16.16 values, sometimes any pattern or zero.
   function automatic logic [31:0] rand_element();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      if (r < 70) return 32'h0;
      if (r < 80) return FxOne;
      return $urandom;
   endfunction

   task automatic send_matrix(int n, bit gaps);
      for (int k = 0; k < n * n; k++) send_element(rand_element(), gaps);
   endtask

   // Result side: random stalls, or a long hold-off on request.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_result(rsp_tdata, rsp_tlast, rsp_tuser);
         results_seen++;
      end
   end

   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (3000) @(negedge clock);
            hold_off = 0;
         end
         if (sink_mode || $urandom_range(0, 3) != 0) begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat (gap_len() + 1) @(negedge clock);
         end
      end
   end

   initial begin
      #40ms;
      $display("tb: errors");
      $finish;
   end

   initial begin
      int sent;
      int reps;
      logic [31:0] edges [6];
      board = new();
      hold_off = 0;
      sink_mode = 0;
      results_seen = 0;
      sent = 0;
      edges = '{32'h7fffffff, 32'h80000000, 32'h00000001, 32'hffffffff,
                32'h00010000, 32'hffff0000};
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_data = 3'd0;
      req_tvalid = 1'b0;
      req_tdata = 32'h0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset size 4 with identity, then size 1 extremes.
      for (int k = 0; k < 16; k++) send_element((k % 5 == 0) ? FxOne : 32'h0, 0);
      drain();
      write_size(3'd1);
      foreach (edges[i]) send_element(edges[i], 0);
      send_element(32'h0, 0);                 // zero pivot
      drain();
      // Size 0 acts as 1, and sizes beyond the maximum act as the maximum.
      write_size(3'd0);
      send_element(32'h0002_0000, 0);
      drain();
      write_size(3'd7);
      send_matrix(4, 0);
      drain();
      // A size write in the middle of a load restarts it.
      write_size(3'd2);
      send_element(32'h1234_5678, 0);
      send_element(32'hdead_beef, 0);
      write_size(3'd2);
      for (int k = 0; k < 4; k++) send_element(32'h0, 0);   // singular at size 2
      drain();
      // Long hold-off on the result side while elements keep coming.
      write_size(3'd1);
      hold_off = 1;
      for (int k = 0; k < 8; k++) send_element(rand_element(), 0);
      drain();
      sent = 54;

      // Random phases over sizes, pausing until all results are in now and then.
      while (sent < 310) begin
         int n;
         n = $urandom_range(1, 4);
         reps = $urandom_range(1, 4);
         write_size(3'(n));
         sink_mode = ($urandom_range(0, 4) == 0);
         for (int m = 0; m < reps && sent < 310; m++) begin
            send_matrix(n, 1);
            sent += n * n;
            if ($urandom_range(0, 3) == 0)
               wait_empty();
         end
         drain();
      end
      sink_mode = 1;
      drain();

      $display("Inverted %0d matrices (%0d singular), checked %0d result items.",
               board.matrices, board.singular_count, results_seen);
      if (board.errors == 0 && board.exp_elem.size() == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end
endmodule
`default_nettype wire
